/* hw/rtl/mp2_pkg.sv */
// mp2_pkg: shared types and constants for the 2x2 matrix power block
// used by mp2_mac and matrix_power_2x2; no dependencies
package mp2_pkg;

    localparam int COUNT_WIDTH       = 9;
    localparam int MULTS_PER_PRODUCT = 8;
    localparam int STEP_WIDTH        = 4;
    // steps 0..7 issue the eight multiplies, step 8 drains and commits
    localparam logic [STEP_WIDTH-1:0] STEP_LAST = 4'd8;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SQUARE,
        ST_MULT,
        ST_DONE
    } state_t;

    // one multiply request into the shared unit
    typedef struct packed {
        logic       valid;
        logic       second;  // second term of a dot product
        logic [1:0] entry;   // row * 2 + column of the result entry
    } mac_ctrl_t;

endpackage

/* hw/rtl/matrix_power_2x2.sv */
// matrix_power_2x2: 2x2 matrix power by left-to-right square and multiply
// depends on mp2_pkg and mp2_mac (one shared multiplier)
// operation: scan the exponent from its top bit down to the top set bit (the identity for a zero
//   exponent), then one matrix product per square or multiply, each 8 multiplies through the
//   shared multiplier and one commit
// requests: one at a time; s_axis_tready returns in the cycle after the result is taken
// reset: asynchronous active low, returns to idle with no result pending
module matrix_power_2x2 #(
    parameter int ENTRY_WIDTH = 32,
    parameter int EXP_WIDTH   = 31
) (
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // base_top_left, base_top_right, base_bottom_left, base_bottom_right, exponent
    input  logic [8*((4*ENTRY_WIDTH+EXP_WIDTH+7)/8)-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // power_top_left, power_top_right, power_bottom_left, power_bottom_right, mult_count
    output logic [8*((4*ENTRY_WIDTH+mp2_pkg::COUNT_WIDTH+7)/8)-1:0] m_axis_tdata
);
    import mp2_pkg::*;

    localparam int OUT_W = 8 * ((4 * ENTRY_WIDTH + COUNT_WIDTH + 7) / 8);
    localparam int BIT_W = $clog2(EXP_WIDTH);
    localparam logic [BIT_W-1:0] BIT_TOP = BIT_W'(EXP_WIDTH - 1);

    state_t                   state_reg, state_next;
    logic [STEP_WIDTH-1:0]    step_reg, step_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    logic [COUNT_WIDTH-1:0]   count_reg, count_next;
    logic [EXP_WIDTH-1:0]     exp_reg;
    logic [ENTRY_WIDTH-1:0]   base0_reg, base1_reg, base2_reg, base3_reg;
    logic [ENTRY_WIDTH-1:0]   acc0_reg, acc1_reg, acc2_reg, acc3_reg;
    logic [ENTRY_WIDTH-1:0]   nxt0_reg, nxt1_reg, nxt2_reg;

    logic                     ld_input, ld_base, commit, issue;
    mac_ctrl_t                mac_ctl, mac_ctl_q;
    logic [ENTRY_WIDTH-1:0]   op_a, op_b, wr_data;
    logic [ENTRY_WIDTH-1:0]   y0, y1, y2, y3;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            step_reg  <= '0;
            bit_reg   <= '0;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
            bit_reg   <= bit_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        bit_next   = bit_reg;
        count_next = count_reg;
        ld_input   = 1'b0;
        ld_base    = 1'b0;
        commit     = 1'b0;
        issue      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (s_axis_tvalid)
                begin
                    ld_input   = 1'b1;
                    bit_next   = BIT_TOP;
                    count_next = '0;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                // running matrix holds the identity until the top set bit is found
                if (exp_reg[bit_reg])
                begin
                    ld_base = 1'b1;
                end
                if (bit_reg == '0)
                begin
                    state_next = ST_DONE;
                end
                else
                begin
                    bit_next = bit_reg - BIT_W'(1);
                    if (exp_reg[bit_reg])
                    begin
                        step_next  = '0;
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_SQUARE, ST_MULT:
            begin
                if (step_reg != STEP_LAST)
                begin
                    issue     = 1'b1;
                    step_next = step_reg + STEP_WIDTH'(1);
                end
                else
                begin
                    commit     = 1'b1;
                    count_next = count_reg + COUNT_WIDTH'(MULTS_PER_PRODUCT);
                    step_next  = '0;
                    if (state_reg == ST_SQUARE && exp_reg[bit_reg])
                    begin
                        state_next = ST_MULT;
                    end
                    else if (bit_reg == '0)
                    begin
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        bit_next   = bit_reg - BIT_W'(1);
                        state_next = ST_SQUARE;
                    end
                end
            end
            ST_DONE:
            begin
                if (m_axis_tready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // step bits: [2] row, [1] column, [0] term of the dot product
    assign mac_ctl.valid  = issue;
    assign mac_ctl.second = step_reg[0];
    assign mac_ctl.entry  = step_reg[2:1];

    always_comb
    begin
        if (state_reg == ST_SQUARE)
        begin
            y0 = acc0_reg;
            y1 = acc1_reg;
            y2 = acc2_reg;
            y3 = acc3_reg;
        end
        else
        begin
            y0 = base0_reg;
            y1 = base1_reg;
            y2 = base2_reg;
            y3 = base3_reg;
        end
    end

    // a = x[row][term], b = y[term][column]
    always_comb
    begin
        unique case ({step_reg[2], step_reg[0]})
            2'b00:   op_a = acc0_reg;
            2'b01:   op_a = acc1_reg;
            2'b10:   op_a = acc2_reg;
            default: op_a = acc3_reg;
        endcase
        unique case ({step_reg[0], step_reg[1]})
            2'b00:   op_b = y0;
            2'b01:   op_b = y1;
            2'b10:   op_b = y2;
            default: op_b = y3;
        endcase
    end

    mp2_mac #(
        .ENTRY_WIDTH (ENTRY_WIDTH)
    ) u_mac (
        .clk     (clk),
        .rst_n   (rst_n),
        .ctl     (mac_ctl),
        .op_a    (op_a),
        .op_b    (op_b),
        .ctl_q   (mac_ctl_q),
        .wr_data (wr_data)
    );

    always_ff @(posedge clk)
    begin
        if (ld_input)
        begin
            base0_reg <= s_axis_tdata[0*ENTRY_WIDTH +: ENTRY_WIDTH];
            base1_reg <= s_axis_tdata[1*ENTRY_WIDTH +: ENTRY_WIDTH];
            base2_reg <= s_axis_tdata[2*ENTRY_WIDTH +: ENTRY_WIDTH];
            base3_reg <= s_axis_tdata[3*ENTRY_WIDTH +: ENTRY_WIDTH];
            exp_reg   <= s_axis_tdata[4*ENTRY_WIDTH +: EXP_WIDTH];
            acc0_reg  <= ENTRY_WIDTH'(1);
            acc1_reg  <= '0;
            acc2_reg  <= '0;
            acc3_reg  <= ENTRY_WIDTH'(1);
        end
        else if (ld_base)
        begin
            acc0_reg <= base0_reg;
            acc1_reg <= base1_reg;
            acc2_reg <= base2_reg;
            acc3_reg <= base3_reg;
        end
        else if (commit)
        begin
            // last entry comes straight from the accumulator
            acc0_reg <= nxt0_reg;
            acc1_reg <= nxt1_reg;
            acc2_reg <= nxt2_reg;
            acc3_reg <= wr_data;
        end
        if (mac_ctl_q.valid && mac_ctl_q.second)
        begin
            unique case (mac_ctl_q.entry)
                2'd0:    nxt0_reg <= wr_data;
                2'd1:    nxt1_reg <= wr_data;
                2'd2:    nxt2_reg <= wr_data;
                default: ;
            endcase
        end
    end

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = (state_reg == ST_DONE);
    assign m_axis_tdata  = OUT_W'({count_reg, acc3_reg, acc2_reg, acc1_reg, acc0_reg});

    a_one_side: assert property (@(posedge clk) disable iff (!rst_n)
        !(s_axis_tready && m_axis_tvalid))
        else $error("ready for a request while a result is pending");

    a_count_mult8: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg[2:0] == 3'd0)
        else $error("multiply count not a whole number of products");

    a_mac_busy: assert property (@(posedge clk) disable iff (!rst_n)
        mac_ctl_q.valid |-> (state_reg == ST_SQUARE || state_reg == ST_MULT))
        else $error("multiplier result outside a matrix product");

    a_release: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tready) |=> s_axis_tready)
        else $error("not idle after the result was taken");

    a_commit_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> (mac_ctl_q.valid && mac_ctl_q.second && mac_ctl_q.entry == 2'd3))
        else $error("commit without the last entry ready");

endmodule

/* hw/rtl/mp2_mac.sv */
// mp2_mac: shared multiplier with a two-term accumulator, one multiply per cycle
// depends on mp2_pkg
module mp2_mac #(
    parameter int ENTRY_WIDTH = 32
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  mp2_pkg::mac_ctrl_t     ctl,
    input  logic [ENTRY_WIDTH-1:0] op_a,
    input  logic [ENTRY_WIDTH-1:0] op_b,
    output mp2_pkg::mac_ctrl_t     ctl_q,
    output logic [ENTRY_WIDTH-1:0] wr_data
);
    import mp2_pkg::*;

    mac_ctrl_t              ctl_reg;
    logic [ENTRY_WIDTH-1:0] prod_reg;
    logic [ENTRY_WIDTH-1:0] prod_next;
    logic [ENTRY_WIDTH-1:0] sum_reg;

    // only the low half is kept, products wrap
    assign prod_next = op_a * op_b;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ctl_reg <= '0;
        end
        else
        begin
            ctl_reg <= ctl;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.valid)
        begin
            prod_reg <= prod_next;
        end
        if (ctl_reg.valid && !ctl_reg.second)
        begin
            sum_reg <= prod_reg;
        end
    end

    assign ctl_q   = ctl_reg;
    assign wr_data = sum_reg + prod_reg;

endmodule
